// ----- design/srsw_pkg.sv -----
// ----------------------------------------------------------------------------
// Selective repeat sender window package
// Shared constants, codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package srsw_pkg;

  // Default build sizes. The ring depth must be a power of two.
  localparam int unsigned RING_DEPTH_DEF = 16;
  localparam int unsigned SEQ_BITS_DEF   = 16;

  // Field widths of the stream channels.
  localparam int unsigned WIN_W      = 4;
  localparam int unsigned MAX_SEQ_W  = 17;
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLID_W     = 5;
  localparam int unsigned FREE_W     = 4;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Register reset values.
  localparam logic [WIN_W-1:0]     WINDOW_RST  = 4'd8;
  localparam logic [MAX_SEQ_W-1:0] MAX_SEQ_RST = 17'd64;

  // Register index, taken from address bit 2.
  typedef enum logic {
    REG_WINDOW  = 1'b0,
    REG_MAX_SEQ = 1'b1
  } reg_idx_e;

  typedef enum logic {
    OPC_PRODUCE = 1'b0,
    OPC_ACK     = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PRODUCED    = 3'd0,
    ST_RING_FULL   = 3'd1,
    ST_NEW_ACK     = 3'd2,
    ST_REJECTED    = 3'd3,
    ST_END_REACHED = 3'd4
  } status_e;

  // Operand of the remainder unit.
  typedef enum logic {
    MOD_SRC_NEXT = 1'b0,
    MOD_SRC_READ = 1'b1
  } mod_src_e;

  typedef struct packed {
    logic     load_in;
    logic     mod_start;
    mod_src_e mod_src;
    logic     base_rd;
    logic     produce;
    logic     dist_calc;
    logic     win_check;
    logic     ack_write;
    logic     slide_init;
    logic     slide_rd;
    logic     slide_step;
    logic     base_commit;
    logic     set_status;
    status_e  status;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    full;
    logic    empty;
    logic    mod_done;
    logic    win_ok;
    logic    slot_acked;
    logic    d_zero;
    logic    cur_at_prod;
    logic    cur_final;
  } dp_sts_t;

endpackage

// ----- design/srsw_mod.sv -----
// ----------------------------------------------------------------------------
// Sequence remainder unit
// Reduces a stored sequence number modulo the effective modulus. A value
// already below the modulus is loaded straight into the remainder register;
// otherwise a restoring remainder runs one bit per cycle.
// ----------------------------------------------------------------------------
module srsw_mod #(
  parameter int unsigned SW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [SW-1:0] x_i,
  input  logic [SW:0]   m_i,
  output logic          done_o,
  output logic [SW-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(SW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SW-1:0]    xs_q, xs_d;
  logic [SW-1:0]    r_q, r_d;
  logic [SW:0]      r_shift;
  logic [SW:0]      r_next;

  always_comb begin
    r_shift = {r_q, xs_q[SW-1]};
    r_next  = (r_shift >= m_i) ? (r_shift - m_i) : r_shift;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    xs_d   = xs_q;
    r_d    = r_q;
    if (start_i) begin
      if ({1'b0, x_i} < m_i) begin
        r_d    = x_i;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        xs_d   = x_i;
        r_d    = '0;
        cnt_d  = CNT_W'(SW);
      end
    end else if (busy_q) begin
      r_d   = r_next[SW-1:0];
      xs_d  = {xs_q[SW-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q <= xs_d;
    r_q  <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

// ----- design/srsw_dp.sv -----
// ----------------------------------------------------------------------------
// Selective repeat sender window datapath
// Ring indices, slot memories, window check, base slide and result
// registers, driven step by step by the controller.
// ----------------------------------------------------------------------------
module srsw_dp #(
  parameter int unsigned RING_DEPTH = srsw_pkg::RING_DEPTH_DEF,
  parameter int unsigned SEQ_BITS   = srsw_pkg::SEQ_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  srsw_pkg::dp_cmd_t                cmd_i,
  output srsw_pkg::dp_sts_t                sts_o,
  input  logic [srsw_pkg::WIN_W-1:0]       window_i,
  input  logic [srsw_pkg::MAX_SEQ_W-1:0]   max_seq_i,
  input  srsw_pkg::opcode_e                in_opcode_i,
  input  logic [srsw_pkg::SEQ_W-1:0]       in_ack_seq_i,
  input  logic                             in_is_final_i,
  output srsw_pkg::status_e                out_status_o,
  output logic [srsw_pkg::SLID_W-1:0]      out_slid_o,
  output logic [srsw_pkg::SEQ_W-1:0]       out_base_o,
  output logic [srsw_pkg::FREE_W-1:0]      out_free_o
);

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  // Stored sequence width: wide enough for any reduced value.
  localparam int unsigned SW    = (SEQ_BITS > srsw_pkg::SEQ_W) ? SEQ_BITS : srsw_pkg::SEQ_W;
  localparam int unsigned MW    = SW + 1;
  localparam int unsigned FW    = (IDX_W > srsw_pkg::FREE_W) ? IDX_W : srsw_pkg::FREE_W;

  localparam logic [MW-1:0] SEQ_TOP    = MW'(1) << SEQ_BITS;
  localparam logic [MW-1:0] DEPTH_M    = MW'(RING_DEPTH);
  localparam logic [MW-1:0] DEPTH_MASK = ~(MW'(RING_DEPTH - 1));
  localparam logic [FW-1:0] FREE_MAX   = FW'(2 ** srsw_pkg::FREE_W - 1);

  // Slot memories.
  logic [SW-1:0] seq_mem_q [RING_DEPTH];
  logic          ack_mem_q [RING_DEPTH];
  logic          fin_mem_q [RING_DEPTH];

  logic [IDX_W-1:0]           base_q, prod_q, cur_q, slot_q;
  logic [SW-1:0]              next_q;
  logic [srsw_pkg::SLID_W-1:0] slid_q;
  srsw_pkg::status_e          status_q;
  srsw_pkg::opcode_e          op_q;
  logic [srsw_pkg::SEQ_W-1:0] seq_in_q;
  logic                       fin_in_q;
  logic [MW-1:0]              sum_q;
  logic                       seq_bad_q, win_ok_q, d_zero_q;
  logic [SW-1:0]              seq_rd_q;
  logic                       ack_rd_q, fin_rd_q;

  srsw_pkg::status_e           out_status_q;
  logic [srsw_pkg::SLID_W-1:0] out_slid_q;
  logic [srsw_pkg::SEQ_W-1:0]  out_base_q;
  logic [srsw_pkg::FREE_W-1:0] out_free_q;

  logic [MW-1:0]    m_req, m_clamp, m_low, mod_m;
  logic [SW-1:0]    mod_x, mod_rem;
  logic             mod_done;
  logic [IDX_W-1:0] occ;
  logic [MW-1:0]    seq_x, lim, d_w;
  logic [IDX_W-1:0] slot_d;
  logic [MW-1:0]    rem_inc;
  logic [IDX_W-1:0] free_w;
  logic [FW-1:0]    free_ext;
  logic             ack_we, ack_wd, ack_re;
  logic [IDX_W-1:0] ack_wa, ack_ra;

  // Effective modulus: clamped to the ring depth and the sequence space,
  // then rounded down to a whole number of rings.
  always_comb begin
    m_req   = MW'(max_seq_i);
    m_clamp = (m_req > SEQ_TOP) ? SEQ_TOP : m_req;
    m_low   = (m_clamp < DEPTH_M) ? DEPTH_M : m_clamp;
    mod_m   = m_low & DEPTH_MASK;
  end

  assign mod_x = (cmd_i.mod_src == srsw_pkg::MOD_SRC_READ) ? seq_rd_q : next_q;

  srsw_mod #(
    .SW (SW)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mod_start),
    .x_i     (mod_x),
    .m_i     (mod_m),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  always_comb begin
    occ     = prod_q - base_q;
    seq_x   = MW'(seq_in_q);
    lim     = (MW'(window_i) < MW'(occ)) ? MW'(window_i) : MW'(occ);
    d_w     = (sum_q >= mod_m) ? (sum_q - mod_m) : sum_q;
    slot_d  = base_q + d_w[IDX_W-1:0];
    rem_inc = MW'(mod_rem) + MW'(1);
    free_w  = base_q - prod_q - IDX_W'(1);
    free_ext = FW'(free_w);
  end

  // Acked flag memory port control.
  always_comb begin
    ack_we = cmd_i.produce | cmd_i.ack_write;
    ack_wa = cmd_i.produce ? prod_q : slot_q;
    ack_wd = cmd_i.ack_write;
    ack_re = cmd_i.win_check | cmd_i.slide_rd;
    ack_ra = cmd_i.win_check ? slot_d : cur_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.produce) begin
      seq_mem_q[prod_q] <= mod_rem;
      fin_mem_q[prod_q] <= fin_in_q;
    end
    if (cmd_i.base_rd) begin
      seq_rd_q <= seq_mem_q[base_q];
    end
    if (cmd_i.slide_rd) begin
      fin_rd_q <= fin_mem_q[cur_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack_we) begin
      ack_mem_q[ack_wa] <= ack_wd;
    end
    if (ack_re) begin
      ack_rd_q <= ack_mem_q[ack_ra];
    end
  end

  // Ring state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      prod_q   <= '0;
      next_q   <= '0;
      cur_q    <= '0;
      slid_q   <= '0;
      status_q <= srsw_pkg::ST_PRODUCED;
    end else begin
      if (cmd_i.produce) begin
        prod_q <= prod_q + IDX_W'(1);
        next_q <= (rem_inc == mod_m) ? '0 : rem_inc[SW-1:0];
      end
      if (cmd_i.load_in) begin
        slid_q <= '0;
      end
      if (cmd_i.slide_init) begin
        cur_q  <= base_q;
        slid_q <= '0;
      end
      if (cmd_i.slide_step) begin
        cur_q <= cur_q + IDX_W'(1);
        if (slid_q != '1) begin
          slid_q <= slid_q + srsw_pkg::SLID_W'(1);
        end
      end
      if (cmd_i.base_commit) begin
        base_q <= cur_q;
      end
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
    end
  end

  // Item fields, window check and results.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q     <= in_opcode_i;
      seq_in_q <= in_ack_seq_i;
      fin_in_q <= in_is_final_i;
    end
    if (cmd_i.dist_calc) begin
      seq_bad_q <= (seq_x >= mod_m);
      sum_q     <= seq_x + mod_m - MW'(mod_rem);
    end
    if (cmd_i.win_check) begin
      win_ok_q <= !seq_bad_q && (d_w < lim);
      d_zero_q <= (d_w == '0);
      slot_q   <= slot_d;
    end
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_slid_q   <= slid_q;
      out_base_q   <= mod_rem[srsw_pkg::SEQ_W-1:0];
      out_free_q   <= (free_ext > FREE_MAX) ? '1 : free_ext[srsw_pkg::FREE_W-1:0];
    end
  end

  always_comb begin
    sts_o.op          = op_q;
    sts_o.full        = ((prod_q + IDX_W'(1)) == base_q);
    sts_o.empty       = (prod_q == base_q);
    sts_o.mod_done    = mod_done;
    sts_o.win_ok      = win_ok_q;
    sts_o.slot_acked  = ack_rd_q;
    sts_o.d_zero      = d_zero_q;
    sts_o.cur_at_prod = (cur_q == prod_q);
    sts_o.cur_final   = fin_rd_q;
  end

  assign out_status_o = out_status_q;
  assign out_slid_o   = out_slid_q;
  assign out_base_o   = out_base_q;
  assign out_free_o   = out_free_q;

endmodule

// ----- design/srsw_ctrl.sv -----
// ----------------------------------------------------------------------------
// Selective repeat sender window controller
// Sequences one transaction at a time through the datapath and owns both
// stream handshakes.
// ----------------------------------------------------------------------------
module srsw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output srsw_pkg::dp_cmd_t cmd_o,
  input  srsw_pkg::dp_sts_t sts_i
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_DISP = 14'b00000000000010,
    S_ARD  = 14'b00000000000100,
    S_AMOD = 14'b00000000001000,
    S_AWIN = 14'b00000000010000,
    S_AFLG = 14'b00000000100000,
    S_PMOD = 14'b00000001000000,
    S_SCHK = 14'b00000010000000,
    S_SRD  = 14'b00000100000000,
    S_BASE = 14'b00001000000000,
    S_BRD  = 14'b00010000000000,
    S_BMOD = 14'b00100000000000,
    S_DONE = 14'b01000000000000,
    S_SPARE = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    s_tready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.op == srsw_pkg::OPC_PRODUCE) begin
          if (sts_i.full) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = srsw_pkg::ST_RING_FULL;
            state_d          = S_BASE;
          end else begin
            cmd_o.mod_start = 1'b1;
            cmd_o.mod_src   = srsw_pkg::MOD_SRC_NEXT;
            state_d         = S_PMOD;
          end
        end else if (sts_i.empty) begin
          cmd_o.mod_start = 1'b1;
          cmd_o.mod_src   = srsw_pkg::MOD_SRC_NEXT;
          state_d         = S_AMOD;
        end else begin
          cmd_o.base_rd = 1'b1;
          state_d       = S_ARD;
        end
      end
      S_ARD: begin
        cmd_o.mod_start = 1'b1;
        cmd_o.mod_src   = srsw_pkg::MOD_SRC_READ;
        state_d         = S_AMOD;
      end
      S_AMOD: begin
        if (sts_i.mod_done) begin
          cmd_o.dist_calc = 1'b1;
          state_d         = S_AWIN;
        end
      end
      S_AWIN: begin
        cmd_o.win_check = 1'b1;
        state_d         = S_AFLG;
      end
      S_AFLG: begin
        cmd_o.set_status = 1'b1;
        if (!sts_i.win_ok || sts_i.slot_acked) begin
          cmd_o.status = srsw_pkg::ST_REJECTED;
          state_d      = S_BASE;
        end else begin
          cmd_o.status    = srsw_pkg::ST_NEW_ACK;
          cmd_o.ack_write = 1'b1;
          if (sts_i.d_zero) begin
            cmd_o.slide_init = 1'b1;
            state_d          = S_SCHK;
          end else begin
            state_d = S_BASE;
          end
        end
      end
      S_PMOD: begin
        if (sts_i.mod_done) begin
          cmd_o.produce    = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = srsw_pkg::ST_PRODUCED;
          state_d          = S_BASE;
        end
      end
      S_SCHK: begin
        if (sts_i.cur_at_prod) begin
          cmd_o.base_commit = 1'b1;
          state_d           = S_BASE;
        end else begin
          cmd_o.slide_rd = 1'b1;
          state_d        = S_SRD;
        end
      end
      S_SRD: begin
        if (sts_i.slot_acked) begin
          cmd_o.slide_step = 1'b1;
          state_d          = S_SCHK;
        end else begin
          cmd_o.base_commit = 1'b1;
          if (sts_i.cur_final) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = srsw_pkg::ST_END_REACHED;
          end
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        if (sts_i.empty) begin
          cmd_o.mod_start = 1'b1;
          cmd_o.mod_src   = srsw_pkg::MOD_SRC_NEXT;
          state_d         = S_BMOD;
        end else begin
          cmd_o.base_rd = 1'b1;
          state_d       = S_BRD;
        end
      end
      S_BRD: begin
        cmd_o.mod_start = 1'b1;
        cmd_o.mod_src   = srsw_pkg::MOD_SRC_READ;
        state_d         = S_BMOD;
      end
      S_BMOD: begin
        if (sts_i.mod_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_tready) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid = out_valid_q;

endmodule

// ----- design/selective_repeat_sender_window_unit.sv -----
// ----------------------------------------------------------------------------
// Selective repeat sender window unit
// Sender-side scoreboard over a ring of packet slots: produces slots,
// checks and records acknowledgements and slides the send base.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_*       in         tuser opcode, tdata ack_seq, tlast is_final
// m_*       out        tuser status, tdata slid_count / base_seq / free_slots
// APB       in/out     window_size at 0x0, max_seq at 0x4
//
// One transaction at a time: s_tready stays low from acceptance until the result is loaded. A
// produce reduces the next sequence number unless the ring is full; an acknowledgement reduces
// the base sequence number, checks and records the flag and, for the base slot, slides the base
// past acknowledged slots. Both then reduce the new base sequence number for the result.
// Reset clears the ring indices and the next sequence number; a flag read from an unproduced slot is never used.
// A result waits in the output register; only a second finished result stalls on m_tready.
//
module selective_repeat_sender_window_unit #(
  parameter int unsigned RING_DEPTH = srsw_pkg::RING_DEPTH_DEF,
  parameter int unsigned SEQ_BITS   = srsw_pkg::SEQ_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [srsw_pkg::SEQ_W-1:0]          s_tdata,   // [15:0] ack_seq
  input  logic                                s_tuser,   // [0] opcode
  input  logic                                s_tlast,   // is_final
  // Result stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [srsw_pkg::OUT_DATA_W-1:0]     m_tdata,   // [4:0] slid_count,
                                                         // [20:5] base_seq,
                                                         // [24:21] free_slots
  output logic [srsw_pkg::STATUS_W-1:0]       m_tuser,   // [2:0] status
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [srsw_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [srsw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [srsw_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned PAD_W = srsw_pkg::OUT_DATA_W - srsw_pkg::FREE_W
                                  - srsw_pkg::SEQ_W - srsw_pkg::SLID_W;

  // Configuration registers. The register is selected by address bit 2;
  // writes complete in the access phase and pready is tied high.
  logic [srsw_pkg::WIN_W-1:0]     window_q;
  logic [srsw_pkg::MAX_SEQ_W-1:0] max_seq_q;
  logic                           cfg_we;
  srsw_pkg::reg_idx_e             reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = srsw_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= srsw_pkg::WINDOW_RST;
      max_seq_q <= srsw_pkg::MAX_SEQ_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        srsw_pkg::REG_WINDOW:  window_q  <= pwdata[srsw_pkg::WIN_W-1:0];
        srsw_pkg::REG_MAX_SEQ: max_seq_q <= pwdata[srsw_pkg::MAX_SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      srsw_pkg::REG_WINDOW:  prdata = srsw_pkg::APB_DATA_W'(window_q);
      srsw_pkg::REG_MAX_SEQ: prdata = srsw_pkg::APB_DATA_W'(max_seq_q);
      default:               prdata = '0;
    endcase
  end

  // Controller and datapath.
  srsw_pkg::dp_cmd_t           cmd;
  srsw_pkg::dp_sts_t           sts;
  srsw_pkg::status_e           out_status;
  logic [srsw_pkg::SLID_W-1:0] out_slid;
  logic [srsw_pkg::SEQ_W-1:0]  out_base;
  logic [srsw_pkg::FREE_W-1:0] out_free;

  srsw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  srsw_dp #(
    .RING_DEPTH (RING_DEPTH),
    .SEQ_BITS   (SEQ_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .window_i      (window_q),
    .max_seq_i     (max_seq_q),
    .in_opcode_i   (srsw_pkg::opcode_e'(s_tuser)),
    .in_ack_seq_i  (s_tdata),
    .in_is_final_i (s_tlast),
    .out_status_o  (out_status),
    .out_slid_o    (out_slid),
    .out_base_o    (out_base),
    .out_free_o    (out_free)
  );

  assign m_tdata = {{PAD_W{1'b0}}, out_free, out_base, out_slid};
  assign m_tuser = out_status;

endmodule
